### hdl/flps_pkg.sv
// Shared types and constants for the framed LED pattern sequencer.
package flps_pkg;

  localparam int PATTERN_BITS = 8;
  localparam int IDX_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
  localparam logic [7:0] FRAME_START = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RIGHT  = 3'd1,
    PH_LEFT   = 3'd2,
    PH_PER_HI = 3'd3,
    PH_PER_LO = 3'd4
  } phase_t;

  typedef struct packed {
    logic        right_lamp_pin;
    logic        left_lamp_pin;
    logic        frame_done;
    logic [7:0]  saved_right;
    logic [7:0]  saved_left;
    logic [15:0] saved_period;
  } result_t;

endpackage

### hdl/flps_core.sv
// Frame parser, tick sequencer and lamp pin logic for one accepted transaction.
module flps_core
  import flps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       opcode,
  input  logic [7:0] byte_value,
  input  logic       trigger_level,
  output result_t    result
);

  phase_t            phase, phase_next;
  logic [7:0]        right_pattern, right_pattern_next;
  logic [7:0]        left_pattern, left_pattern_next;
  logic [15:0]       step_period, step_period_next;
  logic [IDX_W-1:0]  bit_index, bit_index_next;
  logic [15:0]       tick_count, tick_count_next;
  logic              done;
  logic [15:0]       period;
  logic [15:0]       tick_inc;
  logic [IDX_W:0]    idx_inc;
  logic [7:0]        right_sh, left_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      right_pattern <= '0;
      left_pattern  <= '0;
      step_period   <= '0;
      bit_index     <= '0;
      tick_count    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      right_pattern <= right_pattern_next;
      left_pattern  <= left_pattern_next;
      step_period   <= step_period_next;
      bit_index     <= bit_index_next;
      tick_count    <= tick_count_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    right_pattern_next = right_pattern;
    left_pattern_next  = left_pattern;
    step_period_next   = step_period;
    done               = 1'b0;
    if (opcode == OP_BYTE) begin
      if (byte_value == FRAME_START) begin
        phase_next = PH_RIGHT;
      end else begin
        case (phase)
          PH_RIGHT: begin
            right_pattern_next = byte_value;
            phase_next         = PH_LEFT;
          end
          PH_LEFT: begin
            left_pattern_next = byte_value;
            phase_next        = PH_PER_HI;
          end
          PH_PER_HI: begin
            step_period_next = {byte_value, 8'h00};
            phase_next       = PH_PER_LO;
          end
          PH_PER_LO: begin
            step_period_next = {step_period[15:8], step_period[7:0] | byte_value};
            phase_next       = PH_IDLE;
            done             = 1'b1;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_comb begin
    period          = (step_period == '0) ? 16'd1 : step_period;
    tick_inc        = tick_count + 16'd1;
    idx_inc         = {1'b0, bit_index} + {{IDX_W{1'b0}}, 1'b1};
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    if (!trigger_level) begin
      bit_index_next  = '0;
      tick_count_next = '0;
    end else if (opcode == OP_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc >= period) begin
        tick_count_next = '0;
        if (idx_inc >= (IDX_W+1)'(PATTERN_BITS)) begin
          bit_index_next = '0;
        end else begin
          bit_index_next = idx_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_comb begin
    right_sh              = right_pattern_next >> bit_index_next;
    left_sh               = left_pattern_next >> bit_index_next;
    result.right_lamp_pin = trigger_level & ~right_sh[0];
    result.left_lamp_pin  = trigger_level & ~left_sh[0];
    result.frame_done     = done;
    result.saved_right    = done ? right_pattern_next : 8'h00;
    result.saved_left     = done ? left_pattern_next : 8'h00;
    result.saved_period   = done ? step_period_next : 16'h0000;
  end

endmodule

### hdl/framed_led_pattern_sequencer_top.sv
// Top level: stream ports, frame and tick processing, registered result.
// Each accepted transaction is a serial byte or a timer tick and yields one
// result, registered in a single output register. A new transaction
// is taken every clock while the result side accepts; the block stalls only
// while that output register holds an untaken result.
module framed_led_pattern_sequencer_top
  import flps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] byte_value, [8] trigger_level, [15:9] zero
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] right_lamp_pin, [1] left_lamp_pin, [2] frame_done,
                                 // [10:3] saved_right, [18:11] saved_left,
                                 // [34:19] saved_period, [39:35] zero
);

  logic    accept;
  result_t result;
  result_t out_reg;
  logic    out_valid;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  flps_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .opcode        (s_tuser),
    .byte_value    (s_tdata[7:0]),
    .trigger_level (s_tdata[8]),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_reg.saved_period, out_reg.saved_left, out_reg.saved_right,
                     out_reg.frame_done, out_reg.left_lamp_pin, out_reg.right_lamp_pin};

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the framed LED pattern sequencer top level.
module testbench;
  import flps_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  class lamp_scoreboard;
    phase_t           phase;
    logic [7:0]       right_pat;
    logic [7:0]       left_pat;
    logic [15:0]      period;
    logic [15:0]      tick_cnt;
    logic [IDX_W-1:0] idx;
    result_t          pending[$];
    int               errors;
    int               items_in;
    int               results_out;
    int               frames;
    int               steps;

    function new();
      phase = PH_IDLE;
      right_pat = '0;
      left_pat = '0;
      period = '0;
      tick_cnt = '0;
      idx = '0;
      errors = 0;
      items_in = 0;
      results_out = 0;
      frames = 0;
      steps = 0;
    endfunction

    function logic lamp_level(logic [7:0] pat);
      return !((int'(idx) < 8) && pat[idx]);
    endfunction

    function result_t advance_lamps(logic op, logic [7:0] b, logic trig);
      result_t     r;
      logic [15:0] limit;
      int          nxt;
      r = '0;
      if (op == OP_BYTE) begin
        if (b == FRAME_START) begin
          phase = PH_RIGHT;
        end else begin
          case (phase)
            PH_RIGHT: begin
              right_pat = b;
              phase = PH_LEFT;
            end
            PH_LEFT: begin
              left_pat = b;
              phase = PH_PER_HI;
            end
            PH_PER_HI: begin
              period = {b, 8'h00};
              phase = PH_PER_LO;
            end
            PH_PER_LO: begin
              period = period | {8'h00, b};
              phase = PH_IDLE;
              r.frame_done = 1'b1;
              r.saved_right = right_pat;
              r.saved_left = left_pat;
              r.saved_period = period;
              frames++;
            end
            default: ;
          endcase
        end
      end
      if (!trig) begin
        idx = '0;
        tick_cnt = '0;
      end else begin
        if (op == OP_TICK) begin
          limit = (period == 16'd0) ? 16'd1 : period;
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= limit) begin
            tick_cnt = '0;
            nxt = int'(idx) + 1;
            if (nxt >= PATTERN_BITS) nxt = 0;
            idx = IDX_W'(nxt);
            steps++;
          end
        end
        r.right_lamp_pin = lamp_level(right_pat);
        r.left_lamp_pin = lamp_level(left_pat);
      end
      return r;
    endfunction

    function void note_item(logic op, logic [7:0] b, logic trig);
      pending.push_back(advance_lamps(op, b, trig));
      items_in++;
    endfunction

    task report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_out, got, want);
    endtask

    task check_result(logic [39:0] d);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", d, '0);
      end else begin
        want = pending.pop_front();
        if (d[0] !== want.right_lamp_pin)
          report_mismatch("right_lamp_pin", 40'(d[0]), 40'(want.right_lamp_pin));
        if (d[1] !== want.left_lamp_pin)
          report_mismatch("left_lamp_pin", 40'(d[1]), 40'(want.left_lamp_pin));
        if (d[2] !== want.frame_done)
          report_mismatch("frame_done", 40'(d[2]), 40'(want.frame_done));
        if (d[10:3] !== want.saved_right)
          report_mismatch("saved_right", 40'(d[10:3]), 40'(want.saved_right));
        if (d[18:11] !== want.saved_left)
          report_mismatch("saved_left", 40'(d[18:11]), 40'(want.saved_left));
        if (d[34:19] !== want.saved_period)
          report_mismatch("saved_period", 40'(d[34:19]), 40'(want.saved_period));
        results_out++;
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] byte_value, [8] trigger_level, [15:9] zero
  logic        s_tuser;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [0] right_lamp_pin, [1] left_lamp_pin, [2] frame_done,
                          // [10:3] saved_right, [18:11] saved_left,
                          // [34:19] saved_period, [39:35] zero
  bit          quiet;
  int          idle_cycles;

  lamp_scoreboard sb = new();

  framed_led_pattern_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata[7:0], s_tdata[8]);
    end
  end

  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic op, logic [7:0] b, logic trig);
    while (!quiet && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'b0, trig, b};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(logic [7:0] r, logic [7:0] l, logic [7:0] h, logic [7:0] lo,
                            logic trig);
    send(OP_BYTE, FRAME_START, trig);
    send(OP_BYTE, r, trig);
    send(OP_BYTE, l, trig);
    send(OP_BYTE, h, trig);
    send(OP_BYTE, lo, trig);
  endtask

  task automatic tick_run(int n, int high_pct);
    repeat (n) send(OP_TICK, 8'($urandom), $urandom_range(99) < high_pct);
  endtask

  initial begin
    logic [7:0] b;
    logic [7:0] h;
    logic [7:0] lo;
    int         pick;
    bit         pressed;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    quiet = 1'b0;
    idle_cycles = 0;
    pressed = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset period is zero, so every tick with the trigger high steps until a frame completes
    send(OP_TICK, 8'h00, 1'b0);
    send(OP_TICK, 8'hFF, 1'b1);
    send(OP_BYTE, 8'h5A, 1'b1);
    send(OP_BYTE, FRAME_START, 1'b1);
    send(OP_BYTE, 8'hA5, 1'b1);
    send(OP_BYTE, 8'h3C, 1'b1);
    send(OP_BYTE, FRAME_START, 1'b1);
    repeat (9) send(OP_TICK, 8'h00, 1'b1);
    send(OP_BYTE, 8'hFF, 1'b0);
    send(OP_BYTE, 8'h80, 1'b1);
    send(OP_BYTE, 8'hFF, 1'b1);
    send(OP_BYTE, FRAME_START, 1'b1);
    send(OP_BYTE, 8'hFF, 1'b1);
    send(OP_BYTE, 8'hFF, 1'b1);
    send(OP_BYTE, 8'hFF, 1'b1);
    send(OP_BYTE, 8'hFF, 1'b1);
    send(OP_TICK, 8'h00, 1'b1);

    // hold the period as it is: never let a nonzero byte land on the period
    while (sb.items_in < 30) begin
      b = (sb.phase == PH_PER_HI) ? FRAME_START : 8'h01;
      send(OP_BYTE, b, 1'b1);
    end
    while (sb.items_in < 120) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        tick_run($urandom_range(12, 1), 90);
      end else if (pick < 70) begin
        send(OP_BYTE, FRAME_START, 1'b1);
        send(OP_BYTE, 8'($urandom_range(255, 1)), 1'b1);
        send(OP_BYTE, 8'($urandom_range(255, 1)), $urandom_range(9) != 0);
      end else begin
        b = ($urandom_range(3) == 0) ? FRAME_START : 8'($urandom_range(255, 1));
        if (sb.phase == PH_PER_HI) b = FRAME_START;
        send(OP_BYTE, b, $urandom_range(9) != 0);
      end
    end

    send_frame(8'h01, 8'h80, 8'h01, 8'h01, 1'b1);
    tick_run(20, 100);

    while (sb.items_in < 250) begin
      quiet = (sb.items_in >= 165) && (sb.items_in < 215);
      if (!pressed && sb.items_in >= 225) begin
        pressed = 1'b1;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        h = ($urandom_range(1) == 0) ? 8'h01 : 8'($urandom_range(255, 1));
        lo = ($urandom_range(9) == 0) ? FRAME_START : 8'($urandom_range(255, 1));
        send_frame(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)), h, lo,
                   $urandom_range(9) != 0);
        tick_run($urandom_range(20, 1), 90);
      end else if (pick < 50) begin
        send(OP_BYTE, FRAME_START, 1'b1);
        repeat ($urandom_range(3)) send(OP_BYTE, 8'($urandom_range(255, 1)), 1'b1);
      end else if (pick < 70) begin
        send(OP_BYTE, 8'($urandom), 1'($urandom_range(1)));
      end else begin
        tick_run($urandom_range(15, 1), 85);
      end
    end
    quiet = 1'b0;

    // step the index at the shortest framed period, with the count past 256
    send_frame(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)), 8'h01, 8'h01, 1'b1);
    tick_run(257 + 20, 100);

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("Covered %0d transactions in and %0d results out, %0d completed frames,",
             sb.items_in, sb.results_out, sb.frames);
    $display("and %0d lamp index steps with random stalls on both sides.", sb.steps);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
